// ----- rtl/tcvwp_pkg.sv -----
package tcvwp_pkg;

  localparam int VALUE_WIDTH = 20;
  localparam int WORD_WIDTH  = 32;
  localparam int CFG_WIDTH   = 5;
  localparam int CFG_IDX_W   = 2;
  // bit counts below twice the word width
  localparam int FILL_W      = $clog2(WORD_WIDTH) + 1;
  localparam int LEN_W       = $clog2(VALUE_WIDTH + 1) + 1;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_SHORT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LONG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SHORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_LONG  = 2'd3;

  localparam logic [CFG_WIDTH-1:0] RUN_SHORT_RST   = 5'd10;
  localparam logic [CFG_WIDTH-1:0] RUN_LONG_RST    = 5'd20;
  localparam logic [CFG_WIDTH-1:0] PIXEL_SHORT_RST = 5'd8;
  localparam logic [CFG_WIDTH-1:0] PIXEL_LONG_RST  = 5'd16;

  // One classified beat: either a flush or a code of nbits right-aligned bits.
  typedef struct packed {
    logic                  flush;
    logic [FILL_W-1:0]     nbits;
    logic [WORD_WIDTH-1:0] code;
    logic                  err;
  } op_t;

endpackage

// ----- rtl/two_class_variable_width_packer_top.sv -----
// Two-class variable-width packer. Values alternate run count and pixel value;
// each is coded as one class bit plus the value at the short or long width of
// its kind and packed MSB first into 32-bit words. One item is accepted per
// clock while in_stall_o is low: the classifier (length encode, compare,
// mask) works on the item in its accepting cycle and hands it through a
// two-entry queue to the packer's shift-merge; a finished word sits in an
// output register, so out_valid_o rises only after the item that completes
// it has been written into the queue and then popped by the packer. While
// a word is held the packer stops, the queue fills after two beats and
// in_stall_o rises; it drops in the cycle after the packer takes a beat again.
// A flush with no pending bits gives no word. width_error is sticky until
// reset. Configuration writes are always ready; issue them only while idle.
module two_class_variable_width_packer_top import tcvwp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_WIDTH-1:0]   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WORD_WIDTH-1:0]  packed_word_o,
  output logic [FILL_W-1:0]      valid_bits_o,
  output logic                   width_error_o,
  output logic                   last_o
);

  op_t  front_op, queue_op;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;

  tcvwp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .op_o        (front_op)
  );

  tcvwp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_op),
    .pop_i   (pop),
    .rdata_o (queue_op),
    .full_o  (full),
    .empty_o (empty)
  );

  tcvwp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .op_i          (queue_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_word_o (packed_word_o),
    .valid_bits_o  (valid_bits_o),
    .width_error_o (width_error_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/tcvwp_front.sv -----
module tcvwp_front import tcvwp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_WIDTH-1:0]   cfg_data_i,
  input  logic                   push_i,
  input  logic                   mode_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output op_t                    op_o
);

  logic [CFG_WIDTH-1:0] run_short_q, run_long_q, pixel_short_q, pixel_long_q;
  logic                 pixel_turn_q, pixel_turn_d;
  logic                 err_q, err_d;

  logic [CFG_WIDTH-1:0]  sw, lw, w;
  logic [LEN_W-1:0]      len;
  logic                  cls;
  logic [WORD_WIDTH-1:0] val_ext, mask, code;

  always_comb begin
    len = LEN_W'(1);
    for (int i = 1; i < VALUE_WIDTH; i++) begin
      if (value_i[i]) len = LEN_W'(i + 1);
    end
  end

  always_comb begin
    sw      = pixel_turn_q ? pixel_short_q : run_short_q;
    lw      = pixel_turn_q ? pixel_long_q  : run_long_q;
    cls     = len > LEN_W'(sw);
    w       = cls ? lw : sw;
    val_ext = WORD_WIDTH'(value_i);
    mask    = ~({WORD_WIDTH{1'b1}} << w);
    code    = (val_ext & mask) | (WORD_WIDTH'(cls) << w);

    pixel_turn_d = pixel_turn_q;
    err_d        = err_q;
    if (push_i) begin
      if (mode_i) begin
        pixel_turn_d = 1'b0;
      end else begin
        pixel_turn_d = ~pixel_turn_q;
        if (cls && (len > LEN_W'(lw))) err_d = 1'b1;
      end
    end

    op_o.flush = mode_i;
    op_o.nbits = FILL_W'(w) + FILL_W'(1);
    op_o.code  = code;
    op_o.err   = mode_i ? err_q : err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_short_q   <= RUN_SHORT_RST;
      run_long_q    <= RUN_LONG_RST;
      pixel_short_q <= PIXEL_SHORT_RST;
      pixel_long_q  <= PIXEL_LONG_RST;
      pixel_turn_q  <= 1'b0;
      err_q         <= 1'b0;
    end else begin
      pixel_turn_q <= pixel_turn_d;
      err_q        <= err_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RUN_SHORT:   run_short_q   <= cfg_data_i;
          REG_RUN_LONG:    run_long_q    <= cfg_data_i;
          REG_PIXEL_SHORT: pixel_short_q <= cfg_data_i;
          REG_PIXEL_LONG:  pixel_long_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/tcvwp_fifo.sv -----
module tcvwp_fifo import tcvwp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  wdata_i,
  input  logic pop_i,
  output op_t  rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  op_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/tcvwp_back.sv -----
module tcvwp_back import tcvwp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  op_t                   op_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [WORD_WIDTH-1:0] packed_word_o,
  output logic [FILL_W-1:0]     valid_bits_o,
  output logic                  width_error_o,
  output logic                  last_o
);

  localparam int CAT_W = 2 * WORD_WIDTH;
  localparam int SH_W  = FILL_W + 1;

  logic [WORD_WIDTH-1:0] partial_q, partial_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  out_valid_q;
  logic [WORD_WIDTH-1:0] word_q;
  logic [FILL_W-1:0]     bits_q;
  logic                  err_q, last_q;

  logic [SH_W-1:0]       sh;
  logic [FILL_W-1:0]     total;
  logic [CAT_W-1:0]      cat;
  logic                  emit;
  logic [WORD_WIDTH-1:0] emit_word;
  logic [FILL_W-1:0]     emit_bits;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    sh    = SH_W'(CAT_W) - SH_W'(fill_q) - SH_W'(op_i.nbits);
    total = fill_q + op_i.nbits;
    cat   = {partial_q, WORD_WIDTH'(0)} | (CAT_W'(op_i.code) << sh);

    emit      = 1'b0;
    emit_word = cat[CAT_W-1:WORD_WIDTH];
    emit_bits = FILL_W'(WORD_WIDTH);
    partial_d = partial_q;
    fill_d    = fill_q;
    if (op_i.flush) begin
      emit      = fill_q != '0;
      emit_word = partial_q;
      emit_bits = fill_q;
      partial_d = '0;
      fill_d    = '0;
    end else if (total >= FILL_W'(WORD_WIDTH)) begin
      // word complete, spill goes to the next one
      emit      = 1'b1;
      partial_d = cat[WORD_WIDTH-1:0];
      fill_d    = total - FILL_W'(WORD_WIDTH);
    end else begin
      partial_d = cat[CAT_W-1:WORD_WIDTH];
      fill_d    = total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (pop_o) begin
        partial_q <= partial_d;
        fill_q    <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      word_q <= emit_word;
      bits_q <= emit_bits;
      err_q  <= op_i.err;
      last_q <= op_i.flush;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = word_q;
  assign valid_bits_o  = bits_q;
  assign width_error_o = err_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_fill_below_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(WORD_WIDTH))
    else $error("fill count reached word width");
  a_full_word_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (bits_q == FILL_W'(WORD_WIDTH)))
    else $error("non-flush word not full");
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && op_i.flush) |=> (fill_q == '0 && partial_q == '0))
    else $error("flush left bits behind");
  a_no_pop_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("pop while output held");
`endif

endmodule
